[hdl/fwsmg_pkg.sv]
// ----------------------------------------------------------------------------
// Failure window safe mode guard: shared package
// Types, codes and defaults used by the guard's controller, datapath and top.
// ----------------------------------------------------------------------------
package fwsmg_pkg;

  // Default depth of the failure stamp FIFO.
  localparam int MAX_FAILURES_DEF = 16;

  // Field widths.
  localparam int CMD_W   = 2;
  localparam int TIME_W  = 48;
  localparam int MS_W    = 32;
  localparam int THR_W   = 5;
  localparam int END_W   = TIME_W + 1;
  localparam int CFG_IDX_W = 2;

  // Command codes carried by an input item.
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REJECT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_ANOMALY = 2'd2;
  localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLED  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FAILURES = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN = 2'd3;

  // Configuration reset values.
  localparam logic             ENABLED_RST  = 1'b1;
  localparam logic [THR_W-1:0] FAILURES_RST = 5'd5;
  localparam logic [MS_W-1:0]  WINDOW_RST   = 32'd60000;
  localparam logic [MS_W-1:0]  COOLDOWN_RST = 32'd30000;

  // Input item.
  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TIME_W-1:0] now_ms;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic            in_safe_mode;
    logic            accept_clients;
    logic            anomaly_latched;
    logic [MS_W-1:0] cooldown_left_ms;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic latch_set;  // set the anomaly latch
    logic latch_clr;  // clear the anomaly latch
    logic pop;        // drop the oldest stamp
    logic clear;      // end counted safe mode and empty the FIFO
    logic push;       // stamp the current time
    logic check;      // compare the count with the threshold
    logic out_load;   // form the result into the output register
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic             enabled;
    logic [CMD_W-1:0] cmd;
    logic             latched;
    logic             counted;
    logic             expired;
    logic             prune_hit;
  } dp_sts_t;

endpackage

[hdl/failure_window_safe_mode_guard.sv]
// ----------------------------------------------------------------------------
// Failure window safe mode guard
// Sliding window circuit breaker: counts client rejections inside a time
// window, enters safe mode for a cooldown when a threshold is reached, and
// holds safe mode while an anomaly latch is set.
//
//   Channel  Direction  Handshake            Payload
//   in_      input      in_valid / in_stall  in_item_t (cmd, now_ms)
//   out_     output     out_valid/out_stall  out_item_t (mode, admission, left)
//   cfg_     input      cfg_we               cfg_index, cfg_data
//
// An item holds the input until its result is loaded into the output register;
// a rejection that is stamped also passes through the push, prune and check
// steps. The prune loop pops one stamp a cycle through the single read port
// of the stamp memory, at most MAX_FAILURES + 1 pops per item.
// Reset is synchronous and active low; the stamp memory needs no clearing.
// A new beat is accepted while the previous result still waits in the output
// register; a stalled result holds the sequencer only at its final step.
// ----------------------------------------------------------------------------
module failure_window_safe_mode_guard
  import fwsmg_pkg::*;
#(
  parameter int MAX_FAILURES = MAX_FAILURES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data
);

  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;

  // Sequencer and handshakes.
  fwsmg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (dp_cmd)
  );

  // Storage and arithmetic.
  fwsmg_dp #(
    .MAX_FAILURES (MAX_FAILURES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .sts       (dp_sts),
    .out_data  (out_data)
  );

endmodule

[hdl/fwsmg_dp.sv]
// ----------------------------------------------------------------------------
// Failure window safe mode guard: datapath
// Holds the configuration, the failure stamp FIFO, the mode flags, the
// cooldown end time and the output register, and acts on controller commands.
// ----------------------------------------------------------------------------
module fwsmg_dp
  import fwsmg_pkg::*;
#(
  parameter int MAX_FAILURES = MAX_FAILURES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MS_W-1:0]      cfg_data,
  input  in_item_t             in_data,
  input  dp_cmd_t              cmd,
  output dp_sts_t              sts,
  output out_item_t            out_data
);

  localparam int IDX_W = (MAX_FAILURES > 1) ? $clog2(MAX_FAILURES) : 1;
  localparam int CNT_W = $clog2(MAX_FAILURES + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FAILURES - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_FAILURES);
  localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(MAX_FAILURES);

  // Configuration registers.
  logic             enabled_r;
  logic [THR_W-1:0] failures_r;
  logic [MS_W-1:0]  window_r;
  logic [MS_W-1:0]  cooldown_r;

  // Captured item and derived pruning cutoff.
  logic [CMD_W-1:0]  cmd_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] cutoff_r;
  logic              no_prune_r;

  // FIFO control and mode state.
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             counted_r, counted_nxt;
  logic             latch_r, latch_nxt;
  logic [END_W-1:0] end_r, end_nxt;

  // Stamp memory and its registered front read.
  logic [TIME_W-1:0] stamp_mem [MAX_FAILURES];
  logic [TIME_W-1:0] front_r;

  out_item_t out_r;

  logic [IDX_W-1:0] head_inc;
  logic [SUM_W-1:0] slot_sum;
  logic [IDX_W-1:0] slot;
  logic             full;
  logic [END_W-1:0] now_ext;
  logic [END_W-1:0] left_diff;
  logic [MS_W-1:0]  left_ms;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r  <= ENABLED_RST;
      failures_r <= FAILURES_RST;
      window_r   <= WINDOW_RST;
      cooldown_r <= COOLDOWN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ENABLED:  enabled_r  <= cfg_data[0];
        CFG_FAILURES: failures_r <= cfg_data[THR_W-1:0];
        CFG_WINDOW:   window_r   <= cfg_data;
        CFG_COOLDOWN: cooldown_r <= cfg_data;
        default:      ;
      endcase
    end
  end

  // Capture the accepted beat and work out the pruning cutoff once.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r      <= in_data.cmd;
      now_r      <= in_data.now_ms;
      no_prune_r <= in_data.now_ms < TIME_W'(window_r);
      cutoff_r   <= in_data.now_ms - TIME_W'(window_r);
    end
  end

  // FIFO addressing.
  assign full     = (count_r == FULL_CNT);
  assign head_inc = (head_r == LAST_IDX) ? '0 : head_r + 1'b1;
  assign slot_sum = SUM_W'(head_r) + SUM_W'(count_r);

  always_comb begin
    if (full) begin
      // A full FIFO overwrites its oldest stamp.
      slot = head_r;
    end else if (slot_sum >= DEPTH_S) begin
      slot = IDX_W'(slot_sum - DEPTH_S);
    end else begin
      slot = IDX_W'(slot_sum);
    end
  end

  // Next FIFO and mode state.
  always_comb begin
    head_nxt    = head_r;
    count_nxt   = count_r;
    counted_nxt = counted_r;
    latch_nxt   = latch_r;
    end_nxt     = end_r;
    if (cmd.clear) begin
      head_nxt    = '0;
      count_nxt   = '0;
      counted_nxt = 1'b0;
    end else if (cmd.pop) begin
      head_nxt  = head_inc;
      count_nxt = count_r - 1'b1;
    end else if (cmd.push) begin
      if (full) begin
        head_nxt = head_inc;
      end else begin
        count_nxt = count_r + 1'b1;
      end
    end
    if (cmd.check && (32'(count_r) >= 32'(failures_r))) begin
      counted_nxt = 1'b1;
      end_nxt     = END_W'(now_r) + END_W'(cooldown_r);
    end
    if (cmd.latch_set) begin
      latch_nxt = 1'b1;
    end else if (cmd.latch_clr) begin
      latch_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= '0;
      count_r   <= '0;
      counted_r <= 1'b0;
      latch_r   <= 1'b0;
      end_r     <= '0;
    end else begin
      head_r    <= head_nxt;
      count_r   <= count_nxt;
      counted_r <= counted_nxt;
      latch_r   <= latch_nxt;
      end_r     <= end_nxt;
    end
  end

  // Stamp memory: one write port, one registered read that follows the head.
  // A write to the entry about to become the front is forwarded.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      stamp_mem[slot] <= now_r;
    end
    if (cmd.push && (slot == head_nxt)) begin
      front_r <= now_r;
    end else begin
      front_r <= stamp_mem[head_nxt];
    end
  end

  // Remaining cooldown, saturated to the field width.
  assign now_ext   = END_W'(now_r);
  assign left_diff = end_r - now_ext;

  always_comb begin
    left_ms = '0;
    if (!latch_r && counted_r && (end_r > now_ext)) begin
      left_ms = (left_diff[END_W-1:MS_W] != '0) ? '1 : left_diff[MS_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r.in_safe_mode     <= latch_r | counted_r;
      out_r.accept_clients   <= !enabled_r | (!counted_r & !latch_r);
      out_r.anomaly_latched  <= latch_r;
      out_r.cooldown_left_ms <= left_ms;
    end
  end

  assign out_data = out_r;

  // Status towards the controller.
  assign sts.enabled   = enabled_r;
  assign sts.cmd       = cmd_r;
  assign sts.latched   = latch_r;
  assign sts.counted   = counted_r;
  assign sts.expired   = now_ext >= end_r;
  assign sts.prune_hit = (count_r != '0) && !no_prune_r && (front_r <= cutoff_r);

endmodule

[hdl/fwsmg_ctrl.sv]
// ----------------------------------------------------------------------------
// Failure window safe mode guard: controller
// Steps one item through command, refresh, pruning and result forming, and
// runs the input and result handshakes.
// ----------------------------------------------------------------------------
module fwsmg_ctrl
  import fwsmg_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_stall,
  output logic    out_valid,
  input  logic    out_stall,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DEC  = 4'd1;
  localparam logic [3:0] ST_REF1 = 4'd2;
  localparam logic [3:0] ST_PUSH = 4'd3;
  localparam logic [3:0] ST_PRN  = 4'd4;
  localparam logic [3:0] ST_CHK  = 4'd5;
  localparam logic [3:0] ST_LOP  = 4'd6;
  localparam logic [3:0] ST_REF2 = 4'd7;
  localparam logic [3:0] ST_DONE = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       in_take;
  logic       out_free;

  assign in_stall  = !rst_n || (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_take) begin
          cmd.load  = 1'b1;
          state_nxt = ST_DEC;
        end
      end
      ST_DEC: begin
        state_nxt = (sts.cmd == CMD_REJECT && sts.enabled) ? ST_REF1 : ST_LOP;
      end
      // Refresh ahead of a counted rejection.
      ST_REF1: begin
        if (sts.latched) begin
          state_nxt = ST_REF2;
        end else if (sts.counted) begin
          if (sts.expired) begin
            cmd.clear = 1'b1;
            state_nxt = ST_PUSH;
          end else begin
            state_nxt = ST_REF2;
          end
        end else if (sts.prune_hit) begin
          cmd.pop = 1'b1;
        end else begin
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_PRN;
      end
      ST_PRN: begin
        if (sts.prune_hit) begin
          cmd.pop = 1'b1;
        end else begin
          state_nxt = ST_CHK;
        end
      end
      ST_CHK: begin
        cmd.check = 1'b1;
        state_nxt = ST_REF2;
      end
      // Latch commands for every item that is not a counted rejection.
      ST_LOP: begin
        cmd.latch_set = (sts.cmd == CMD_ANOMALY) && sts.enabled;
        cmd.latch_clr = (sts.cmd == CMD_CLEAR);
        state_nxt     = ST_REF2;
      end
      // Closing refresh before the result is formed.
      ST_REF2: begin
        if (sts.latched) begin
          state_nxt = ST_DONE;
        end else if (sts.counted) begin
          cmd.clear = sts.expired;
          state_nxt = ST_DONE;
        end else if (sts.prune_hit) begin
          cmd.pop = 1'b1;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result beat valid flag.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[hdl/fwsmg_checker.sv]
// ----------------------------------------------------------------------------
// Failure window safe mode guard: port checker
// Watches the guard's ports and flags results or handshakes that cannot come
// from a correct design.
// ----------------------------------------------------------------------------
module fwsmg_checker
  import fwsmg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  // A stalled result beat stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result beat withdrawn while stalled");

  // A stalled result beat keeps its payload.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_data))
    else $error("result payload changed while stalled");

  // One item at a time: an accepted beat blocks the input in the next cycle.
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second beat accepted while an item is in work");

  // A set latch always shows as safe mode with no cooldown left.
  a_latch_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.anomaly_latched |->
      out_data.in_safe_mode && (out_data.cooldown_left_ms == '0))
    else $error("latched result without safe mode or with cooldown");

  // Cooldown left only in counted safe mode; outside safe mode clients pass.
  a_mode_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.in_safe_mode |->
      out_data.accept_clients && (out_data.cooldown_left_ms == '0))
    else $error("result outside safe mode refuses clients or shows cooldown");

endmodule

bind failure_window_safe_mode_guard fwsmg_checker u_fwsmg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[tb/failure_window_safe_mode_guard_tb.sv]
// ----------------------------------------------------------------------------
// Failure window safe mode guard: testbench
// Sends command beats with timestamps through the input channel and checks
// every result beat against a predictor of the guard that keeps its own
// copy of the stamp FIFO, the safe mode state and the settings. Directed
// tests come first. Randomised phases follow, each with its own settings.
// The sender works in bursts with gaps. The receiver stalls on its own
// pattern and at one point holds off for a long stretch.
// ----------------------------------------------------------------------------
module failure_window_safe_mode_guard_tb;
  import fwsmg_pkg::*;

  localparam int          DEPTH       = MAX_FAILURES_DEF;
  localparam int unsigned HOLD_CYCLES = 400;
  localparam int unsigned TAIL_CYCLES = 50;
  localparam int unsigned MAX_REPORTS = 10;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_PERIODIC,
    STALL_HEAVY
  } stall_mode_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_item_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_data;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_ENABLED;
  logic [MS_W-1:0]      cfg_data = '0;

  // Expected verdicts, oldest first, and the count of failed checks.
  out_item_t   verdict_q[$];
  int unsigned mismatch_count = 0;

  // Long hold-off requests from the tests, taken up by the receiver.
  int unsigned hold_req_n = 0;
  int unsigned hold_seen_n = 0;
  int unsigned hold_left = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int unsigned mode_left = 0;
  int unsigned pat_phase = 0;

  // Predicted guard state and settings.
  logic              g_enabled;
  logic [THR_W-1:0]  g_threshold;
  logic [MS_W-1:0]   g_window;
  logic [MS_W-1:0]   g_cooldown;
  logic [TIME_W-1:0] g_stamps [DEPTH];
  int unsigned       g_count;
  int unsigned       g_head;
  logic              g_counted;
  logic              g_latched;
  logic [END_W-1:0]  g_end;

  failure_window_safe_mode_guard i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Clock with a period of 10.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Puts the predicted state and settings to their reset values.
  function automatic void reset_guard_state();
    g_enabled   = ENABLED_RST;
    g_threshold = FAILURES_RST;
    g_window    = WINDOW_RST;
    g_cooldown  = COOLDOWN_RST;
    for (int i = 0; i < DEPTH; i++) g_stamps[i] = '0;
    g_count   = 0;
    g_head    = 0;
    g_counted = 1'b0;
    g_latched = 1'b0;
    g_end     = '0;
  endfunction

  // Drops stamps at or before now minus the window, unless now is inside
  // the first window.
  function automatic void prune_old_stamps(logic [TIME_W-1:0] now);
    logic [TIME_W-1:0] cutoff;
    if (now >= {16'd0, g_window}) begin
      cutoff = now - {16'd0, g_window};
      while (g_count > 0 && g_stamps[g_head] <= cutoff) begin
        g_head  = (g_head + 1) % DEPTH;
        g_count = g_count - 1;
      end
    end
  endfunction

  // Ends an expired cooldown, or else ages the stamps; frozen while latched.
  function automatic void refresh_guard(logic [TIME_W-1:0] now);
    if (!g_latched) begin
      if (g_counted) begin
        if ({1'b0, now} >= g_end) begin
          g_counted = 1'b0;
          g_count   = 0;
          g_head    = 0;
        end
      end else begin
        prune_old_stamps(now);
      end
    end
  endfunction

  // Stamps a failure; a full FIFO loses its oldest stamp.
  function automatic void push_failure(logic [TIME_W-1:0] now);
    if (g_count >= DEPTH) begin
      g_head  = (g_head + 1) % DEPTH;
      g_count = DEPTH - 1;
    end
    g_stamps[(g_head + g_count) % DEPTH] = now;
    g_count = g_count + 1;
  endfunction

  // Applies one command beat to the predicted state and forms its verdict.
  function automatic out_item_t predict_verdict(in_item_t item);
    out_item_t         v;
    logic [TIME_W-1:0] now;
    logic [END_W-1:0]  left;
    now = item.now_ms;
    case (item.cmd)
      CMD_REJECT: begin
        if (g_enabled) begin
          refresh_guard(now);
          if (!g_counted && !g_latched) begin
            push_failure(now);
            prune_old_stamps(now);
            if (g_count >= g_threshold) begin
              g_counted = 1'b1;
              g_end     = {1'b0, now} + {17'd0, g_cooldown};
            end
          end
        end
      end
      CMD_ANOMALY: begin
        if (g_enabled) g_latched = 1'b1;
      end
      CMD_CLEAR: begin
        g_latched = 1'b0;
      end
      default: begin
      end
    endcase
    refresh_guard(now);
    left = '0;
    if (!g_latched && g_counted && g_end > {1'b0, now}) begin
      left = g_end - {1'b0, now};
      if (left > {17'd0, {MS_W{1'b1}}}) left = {17'd0, {MS_W{1'b1}}};
    end
    v.in_safe_mode     = g_latched || g_counted;
    v.accept_clients   = !g_enabled || (!g_counted && !g_latched);
    v.anomaly_latched  = g_latched;
    v.cooldown_left_ms = left[MS_W-1:0];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side
  // ---------------------------------------------------------------------------

  // Offers one beat and holds it until accepted, then records its verdict.
  // Valid is left high so that a following beat can go back to back.
  task automatic send_beat(logic [CMD_W-1:0] cmd, logic [TIME_W-1:0] now);
    in_item_t item;
    item.cmd    = cmd;
    item.now_ms = now;
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.insert(verdict_q.size(), predict_verdict(item));
  endtask

  // Leaves the input channel idle for a number of cycles.
  task automatic idle_cycles(int unsigned n);
    if (n != 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  // Stops sending and waits until every expected verdict has come back.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Writes all four registers while the guard is idle.
  task automatic apply_settings(logic en, logic [THR_W-1:0] thr, logic [MS_W-1:0] win,
                                logic [MS_W-1:0] cool);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ENABLED;
    cfg_data  <= {{(MS_W-1){1'b0}}, en};
    @(posedge clk);
    cfg_index <= CFG_FAILURES;
    cfg_data  <= {{(MS_W-THR_W){1'b0}}, thr};
    @(posedge clk);
    cfg_index <= CFG_WINDOW;
    cfg_data  <= win;
    @(posedge clk);
    cfg_index <= CFG_COOLDOWN;
    cfg_data  <= cool;
    @(posedge clk);
    cfg_we <= 1'b0;
    g_enabled   = en;
    g_threshold = thr;
    g_window    = win;
    g_cooldown  = cool;
  endtask

  // Random command, weighted towards rejections so that safe mode trips.
  function automatic logic [CMD_W-1:0] pick_cmd();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return CMD_REJECT;
    else if (r < 80) return CMD_QUERY;
    else if (r < 88) return CMD_ANOMALY;
    else return CMD_CLEAR;
  endfunction

  // Next timestamp: mostly small steps forward, sometimes a repeat, and now
  // and then a jump to anywhere in the range, backwards as well.
  function automatic logic [TIME_W-1:0] next_time(logic [TIME_W-1:0] t);
    int unsigned       r;
    logic [15:0]       hi;
    logic [31:0]       lo;
    r  = $urandom_range(0, 99);
    hi = 16'($urandom);
    lo = $urandom;
    if (r < 4) return {hi, lo};
    else if (r < 12) return t;
    else return t + $urandom_range(0, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Receiver side and checking
  // ---------------------------------------------------------------------------

  // Stall pattern: modes of random length, overridden by a long hold-off.
  always @(posedge clk) begin
    pat_phase <= pat_phase + 1;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else if (hold_req_n != hold_seen_n) begin
      hold_seen_n <= hold_req_n;
      hold_left   <= HOLD_CYCLES;
      out_stall   <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      if (mode_left == 0) begin
        stall_mode <= stall_mode_t'($urandom_range(0, 3));
        mode_left  <= $urandom_range(40, 200);
      end else begin
        mode_left <= mode_left - 1;
      end
      case (stall_mode)
        STALL_NONE:     out_stall <= 1'b0;
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 99) < 30);
        STALL_PERIODIC: out_stall <= ((pat_phase % 7) < 3);
        default:        out_stall <= ($urandom_range(0, 99) < 70);
      endcase
    end
  end

  // Compares each accepted result beat with the oldest expected verdict.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        mismatch_count = mismatch_count + 1;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected result beat: safe=%0b accept=%0b latch=%0b left=%0d",
                   out_data.in_safe_mode, out_data.accept_clients,
                   out_data.anomaly_latched, out_data.cooldown_left_ms);
      end else begin
        want = verdict_q.pop_front();
        if (out_data.in_safe_mode !== want.in_safe_mode ||
            out_data.accept_clients !== want.accept_clients ||
            out_data.anomaly_latched !== want.anomaly_latched ||
            out_data.cooldown_left_ms !== want.cooldown_left_ms) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= MAX_REPORTS)
            $display("verdict mismatch: expected safe=%0b accept=%0b latch=%0b left=%0d, %s",
                     want.in_safe_mode, want.accept_clients, want.anomaly_latched,
                     want.cooldown_left_ms,
                     $sformatf("got safe=%0b accept=%0b latch=%0b left=%0d",
                               out_data.in_safe_mode, out_data.accept_clients,
                               out_data.anomaly_latched, out_data.cooldown_left_ms));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset settings: five failures inside the first window trip safe mode,
  // which then runs out exactly at the end of the cooldown.
  task automatic test_reset_defaults();
    send_beat(CMD_QUERY, 48'd0);
    send_beat(CMD_REJECT, 48'd10);
    send_beat(CMD_REJECT, 48'd20);
    send_beat(CMD_REJECT, 48'd30);
    send_beat(CMD_REJECT, 48'd40);
    send_beat(CMD_REJECT, 48'd50);
    send_beat(CMD_QUERY, 48'd30049);
    send_beat(CMD_QUERY, 48'd30050);
  endtask

  // The latch holds while the guard is disabled, ignores further events
  // and is still cleared by a clear command.
  task automatic test_anomaly_latch();
    send_beat(CMD_ANOMALY, 48'd40000);
    apply_settings(1'b0, FAILURES_RST, WINDOW_RST, COOLDOWN_RST);
    send_beat(CMD_QUERY, 48'd40001);
    send_beat(CMD_REJECT, 48'd40002);
    send_beat(CMD_ANOMALY, 48'd40003);
    send_beat(CMD_CLEAR, 48'd40004);
    send_beat(CMD_QUERY, 48'd40005);
    apply_settings(1'b1, FAILURES_RST, WINDOW_RST, COOLDOWN_RST);
  endtask

  // A threshold of zero trips on the first counted rejection; with no
  // cooldown the trip ends within the same beat.
  task automatic test_threshold_zero();
    apply_settings(1'b1, 5'd0, 32'd1000, 32'd0);
    send_beat(CMD_REJECT, 48'd50000);
    apply_settings(1'b1, 5'd0, 32'd1000, 32'd250);
    send_beat(CMD_REJECT, 48'd50010);
    send_beat(CMD_QUERY, 48'd50100);
  endtask

  // The longest cooldown near the top of time, then time going backwards so
  // that the remaining cooldown saturates, then expiry at the top.
  task automatic test_cooldown_saturation();
    apply_settings(1'b1, 5'd1, {MS_W{1'b1}}, {MS_W{1'b1}});
    send_beat(CMD_REJECT, 48'hFFFF_0000_0000);
    send_beat(CMD_QUERY, 48'h0000_0000_1000);
    send_beat(CMD_QUERY, {TIME_W{1'b1}});
  endtask

  // The receiver holds off for a long stretch while beats keep coming, so
  // the guard fills up and stalls its input.
  task automatic test_backpressure();
    logic [TIME_W-1:0] t;
    apply_settings(1'b1, 5'd4, 32'd300, 32'd200);
    t = 48'd100000;
    hold_req_n = hold_req_n + 1;
    for (int k = 0; k < 24; k++) begin
      t = t + $urandom_range(0, 40);
      send_beat((k % 3 == 2) ? CMD_QUERY : CMD_REJECT, t);
    end
    drain_results();
  endtask

  // Randomised phases, each with its own settings, the extremes among them.
  task automatic test_random_traffic();
    int unsigned       burst_left;
    logic [TIME_W-1:0] clock_ms;
    logic              en;
    logic [THR_W-1:0]  thr;
    logic [MS_W-1:0]   win;
    logic [MS_W-1:0]   cool;
    burst_left = 0;
    clock_ms   = 48'd200000;
    for (int p = 0; p < 10; p++) begin
      case (p)
        0: begin en = 1'b1; thr = 5'd3;  win = 32'd200;       cool = 32'd300; end
        1: begin en = 1'b1; thr = 5'd16; win = {MS_W{1'b1}}; cool = {MS_W{1'b1}}; end
        2: begin en = 1'b1; thr = 5'd24; win = 32'd5000;      cool = 32'd100; end
        3: begin en = 1'b0; thr = 5'd2;  win = 32'd100;       cool = 32'd100; end
        4: begin en = 1'b1; thr = 5'd1;  win = 32'd0;         cool = 32'd0;   end
        5: begin en = 1'b1; thr = 5'd0;  win = 32'd300;       cool = 32'd800; end
        6: begin en = 1'b1; thr = 5'd31; win = 32'd2000;      cool = 32'd50;  end
        default: begin
          en   = ($urandom_range(0, 9) != 0);
          thr  = THR_W'($urandom_range(1, 8));
          win  = $urandom_range(20, 1000);
          cool = $urandom_range(0, 3000);
        end
      endcase
      apply_settings(en, thr, win, cool);
      for (int k = 0; k < 62; k++) begin
        // Bursts of random length; some gaps are skipped altogether.
        if (burst_left == 0) begin
          idle_cycles(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
          burst_left = $urandom_range(1, 16);
        end
        burst_left = burst_left - 1;
        clock_ms = next_time(clock_ms);
        send_beat(pick_cmd(), clock_ms);
      end
    end
  endtask

  // A trip at the very top of time whose cooldown end needs the extra bit.
  // The guard cannot leave this state, so it runs last.
  task automatic test_time_ceiling();
    apply_settings(1'b1, 5'd1, 32'd10, 32'd10);
    send_beat(CMD_REJECT, {TIME_W{1'b1}});
    send_beat(CMD_QUERY, {TIME_W{1'b1}});
    send_beat(CMD_QUERY, 48'd5);
  endtask

  // Test sequence.
  initial begin
    reset_guard_state();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_anomaly_latch();
    test_threshold_zero();
    test_cooldown_saturation();
    test_backpressure();
    test_random_traffic();
    test_time_ceiling();
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #5000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
